// ----- sv/thermal_ema_threshold_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// thermal_ema_threshold_monitor_macros.svh
// Assertion macros used by the checker file of the thermal monitor.
// ----------------------------------------------------------------------------
`ifndef THERMAL_EMA_THRESHOLD_MONITOR_MACROS_SVH
`define THERMAL_EMA_THRESHOLD_MONITOR_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define TEMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define TEMT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/temt_pkg.sv -----
// ----------------------------------------------------------------------------
// temt_pkg
// Widths, register indexes, alarm codes and step counts of the thermal monitor.
// ----------------------------------------------------------------------------
package temt_pkg;

    localparam int DATA_W = 16;
    localparam int PCT_W  = 7;
    localparam int IDX_W  = 3;

    localparam logic [PCT_W-1:0] PCT_SCALE  = 7'd100;
    localparam logic [PCT_W-1:0] SMOOTH_RST = 7'd20;

    typedef enum logic [IDX_W-1:0] {
        CFG_SOURCE = 3'd0,
        CFG_MULT   = 3'd1,
        CFG_DIV    = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_SMOOTH = 3'd4,
        CFG_WARN   = 3'd5,
        CFG_CRIT   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALARM_NORMAL = 2'd0,
        ALARM_WARN   = 2'd1,
        ALARM_CRIT   = 2'd2
    } t_alarm;

    // last value of the step counter in each serial phase
    localparam logic [4:0] MUL_CONV_LAST = 5'd15;
    localparam logic [4:0] DIV_CONV_LAST = 5'd31;
    localparam logic [4:0] MUL_MIX_LAST  = 5'd6;
    localparam logic [4:0] DIV_MIX_LAST  = 5'd23;

endpackage

// ----- sv/thermal_ema_threshold_monitor.sv -----
// ----------------------------------------------------------------------------
// thermal_ema_threshold_monitor
// Temperature conversion, exponential average and threshold alarm.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one request: a sample and a
// read_ok flag. A request with read_ok low, or any request after a critical
// alarm, is taken and dropped without a result. Otherwise one result comes out
// on the output channel (o_out_valid / i_out_ready): alarm level and the new
// filtered temperature.
// One item is in work at a time. All arithmetic runs through one shift-add
// multiplier and one restoring divider, one bit per cycle: in ADC mode a
// multiply, a divide, two multiplies and a divide per item; in sensor mode
// only the two multiplies and the last divide.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the block only when the next result is
// ready to be written.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready and writes
// one register per request. Reset restores register defaults, clears the
// average and the halt flag and empties the output register.
// ----------------------------------------------------------------------------
module thermal_ema_threshold_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [temt_pkg::DATA_W-1:0]    i_sample,
    input  logic                                  i_read_ok,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output temt_pkg::t_alarm                      o_alarm_level,
    output logic signed [temt_pkg::DATA_W-1:0]    o_filtered_temperature,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [temt_pkg::IDX_W-1:0]            i_cfg_index,
    input  logic [temt_pkg::DATA_W-1:0]           i_cfg_data
);
    import temt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL1 = 8'b0000_0010,
        S_DIV1 = 8'b0000_0100,
        S_CONV = 8'b0000_1000,
        S_MULA = 8'b0001_0000,
        S_MULB = 8'b0010_0000,
        S_DIV2 = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    function automatic logic [DATA_W:0] f_mag(input logic signed [DATA_W-1:0] v);
        logic [DATA_W:0] ext;
        ext = {v[DATA_W-1], v};
        return v[DATA_W-1] ? ((DATA_W+1)'(0) - ext) : ext;
    endfunction

    // control
    t_state                    r_state, n_state;
    logic [4:0]                r_cnt, n_cnt;
    logic                      r_halted, n_halted;
    logic                      r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0]  r_avg, n_avg;

    // configuration
    logic                      r_src_adc;
    logic [DATA_W-1:0]         r_adc_mult;
    logic [DATA_W-1:0]         r_adc_div;
    logic signed [DATA_W-1:0]  r_adc_off;
    logic [PCT_W-1:0]          r_smooth;
    logic signed [DATA_W-1:0]  r_warn;
    logic signed [DATA_W-1:0]  r_crit;

    // datapath
    logic [DATA_W:0]           r_mcand, n_mcand;
    logic [DATA_W:0]           r_mhi, n_mhi;
    logic [DATA_W-1:0]         r_mlo, n_mlo;
    logic [31:0]               r_num, n_num;
    logic [DATA_W-1:0]         r_rem, n_rem;
    logic [DATA_W-1:0]         r_dvs, n_dvs;
    logic                      r_neg, n_neg;
    logic signed [DATA_W-1:0]  r_temp, n_temp;
    logic signed [23:0]        r_acc, n_acc;
    t_alarm                    r_out_alarm, n_out_alarm;
    logic signed [DATA_W-1:0]  r_out_temp, n_out_temp;

    logic [DATA_W+1:0]         m_sum;
    logic [23:0]               p_last;
    logic signed [23:0]        mix_term;
    logic signed [23:0]        mix_sum;
    logic [23:0]               acc_mag;
    logic [DATA_W:0]           d_try;
    logic [DATA_W:0]           d_diff;
    logic                      d_ge;
    logic [DATA_W-1:0]         d_rem_n;
    logic [PCT_W-1:0]          pct;
    logic [PCT_W-1:0]          pct_inv;
    logic [DATA_W-1:0]         dvs_conv;
    logic signed [33:0]        conv_s;
    logic signed [33:0]        conv_sum;
    logic signed [DATA_W-1:0]  conv_sat;
    logic signed [DATA_W-1:0]  avg_new;
    t_alarm                    level;

    assign o_in_ready             = (r_state == S_IDLE);
    assign o_out_valid            = r_out_valid;
    assign o_alarm_level          = r_out_alarm;
    assign o_filtered_temperature = r_out_temp;
    assign o_cfg_ready            = 1'b1;

    // shared shift-add step and restoring divide step
    assign m_sum   = {1'b0, r_mhi} + (r_mlo[0] ? {1'b0, r_mcand} : (DATA_W+2)'(0));
    assign p_last  = {m_sum[17:0], r_mlo[15:10]};
    assign d_try   = {r_rem, r_num[31]};
    assign d_diff  = d_try - {1'b0, r_dvs};
    assign d_ge    = (d_try >= {1'b0, r_dvs});
    assign d_rem_n = d_ge ? d_diff[DATA_W-1:0] : d_try[DATA_W-1:0];

    assign pct      = (r_smooth > PCT_SCALE) ? PCT_SCALE : r_smooth;
    assign pct_inv  = PCT_SCALE - pct;
    assign dvs_conv = (r_adc_div == '0) ? DATA_W'(1) : r_adc_div;

    assign mix_term = r_neg ? (24'sd0 - $signed(p_last)) : $signed(p_last);
    assign mix_sum  = r_acc + mix_term;
    assign acc_mag  = mix_sum[23] ? (24'd0 - 24'(mix_sum)) : 24'(mix_sum);

    always_comb begin
        conv_s   = $signed({2'b00, r_num});
        if (r_neg) begin
            conv_s = 34'sd0 - conv_s;
        end
        conv_sum = conv_s + 34'(r_adc_off);
        if (conv_sum > 34'sd32767) begin
            conv_sat = 16'sh7FFF;
        end else if (conv_sum < -34'sd32768) begin
            conv_sat = 16'sh8000;
        end else begin
            conv_sat = conv_sum[DATA_W-1:0];
        end
    end

    assign avg_new = r_neg ? $signed(DATA_W'(0) - r_num[DATA_W-1:0])
                           : $signed(r_num[DATA_W-1:0]);

    always_comb begin
        if (avg_new > r_crit) begin
            level = ALARM_CRIT;
        end else if (avg_new > r_warn) begin
            level = ALARM_WARN;
        end else begin
            level = ALARM_NORMAL;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_halted    = r_halted;
        n_out_valid = r_out_valid && !i_out_ready;
        n_avg       = r_avg;
        n_mcand     = r_mcand;
        n_mhi       = r_mhi;
        n_mlo       = r_mlo;
        n_num       = r_num;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_neg       = r_neg;
        n_temp      = r_temp;
        n_acc       = r_acc;
        n_out_alarm = r_out_alarm;
        n_out_temp  = r_out_temp;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_halted && i_read_ok) begin
                    n_mhi = '0;
                    n_cnt = r_src_adc ? MUL_CONV_LAST : MUL_MIX_LAST;
                    if (r_src_adc) begin
                        n_mcand = f_mag(i_sample);
                        n_mlo   = r_adc_mult;
                        n_neg   = i_sample[DATA_W-1];
                        n_state = S_MUL1;
                    end else begin
                        n_temp  = i_sample;
                        n_mcand = f_mag(r_avg);
                        n_mlo   = DATA_W'(pct_inv);
                        n_neg   = r_avg[DATA_W-1];
                        n_state = S_MULA;
                    end
                end
            end
            S_MUL1: begin
                n_mhi = m_sum[DATA_W+1:1];
                n_mlo = {m_sum[0], r_mlo[DATA_W-1:1]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_num   = {m_sum[16:0], r_mlo[15:1]};
                    n_rem   = '0;
                    n_dvs   = dvs_conv;
                    n_cnt   = DIV_CONV_LAST;
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                n_num = {r_num[30:0], d_ge};
                n_rem = d_rem_n;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_temp  = conv_sat;
                n_mcand = f_mag(r_avg);
                n_mhi   = '0;
                n_mlo   = DATA_W'(pct_inv);
                n_neg   = r_avg[DATA_W-1];
                n_cnt   = MUL_MIX_LAST;
                n_state = S_MULA;
            end
            S_MULA: begin
                n_mhi = m_sum[DATA_W+1:1];
                n_mlo = {m_sum[0], r_mlo[DATA_W-1:1]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_acc   = mix_term;
                    n_mcand = f_mag(r_temp);
                    n_mhi   = '0;
                    n_mlo   = DATA_W'(pct);
                    n_neg   = r_temp[DATA_W-1];
                    n_cnt   = MUL_MIX_LAST;
                    n_state = S_MULB;
                end
            end
            S_MULB: begin
                n_mhi = m_sum[DATA_W+1:1];
                n_mlo = {m_sum[0], r_mlo[DATA_W-1:1]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_neg   = mix_sum[23];
                    n_num   = {acc_mag, 8'd0};
                    n_rem   = '0;
                    n_dvs   = DATA_W'(PCT_SCALE);
                    n_cnt   = DIV_MIX_LAST;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                n_num = {r_num[30:0], d_ge};
                n_rem = d_rem_n;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_avg       = avg_new;
                    n_out_alarm = level;
                    n_out_temp  = avg_new;
                    n_out_valid = 1'b1;
                    n_halted    = (level == ALARM_CRIT);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            r_avg       <= '0;
            r_src_adc   <= 1'b1;
            r_adc_mult  <= DATA_W'(1);
            r_adc_div   <= DATA_W'(1);
            r_adc_off   <= '0;
            r_smooth    <= SMOOTH_RST;
            r_warn      <= 16'sd85;
            r_crit      <= 16'sd105;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
            r_avg       <= n_avg;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SOURCE: r_src_adc  <= i_cfg_data[0];
                    CFG_MULT:   r_adc_mult <= i_cfg_data;
                    CFG_DIV:    r_adc_div  <= i_cfg_data;
                    CFG_OFFSET: r_adc_off  <= $signed(i_cfg_data);
                    CFG_SMOOTH: r_smooth   <= i_cfg_data[PCT_W-1:0];
                    CFG_WARN:   r_warn     <= $signed(i_cfg_data);
                    CFG_CRIT:   r_crit     <= $signed(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand     <= n_mcand;
        r_mhi       <= n_mhi;
        r_mlo       <= n_mlo;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_neg       <= n_neg;
        r_temp      <= n_temp;
        r_acc       <= n_acc;
        r_out_alarm <= n_out_alarm;
        r_out_temp  <= n_out_temp;
    end

endmodule

// ----- sv/temt_checker.sv -----
// ----------------------------------------------------------------------------
// temt_checker
// Port-level checks of the thermal monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "thermal_ema_threshold_monitor_macros.svh"

module temt_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_ready,
    input  logic signed [temt_pkg::DATA_W-1:0]    i_sample,
    input  logic                                  i_read_ok,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  temt_pkg::t_alarm                      o_alarm_level,
    input  logic signed [temt_pkg::DATA_W-1:0]    o_filtered_temperature,
    input  logic                                  i_cfg_valid,
    input  logic                                  o_cfg_ready,
    input  logic [temt_pkg::IDX_W-1:0]            i_cfg_index,
    input  logic [temt_pkg::DATA_W-1:0]           i_cfg_data
);
    import temt_pkg::*;

    // protocol: a waiting result stays and holds
    `TEMT_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")
    `TEMT_ASSERT(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_alarm_level) && $stable(o_filtered_temperature), "result changed")

    // reset empties the output register
    `TEMT_ASSERT_ALWAYS(a_rst_empty, $past(!i_rst_n) |-> !o_out_valid, "result after reset")

    // a new result only follows a busy cycle
    `TEMT_ASSERT(a_rose_busy, $rose(o_out_valid) |-> !$past(o_in_ready), "result without work")

    // after critical is taken the block stays halted
    `TEMT_ASSERT(a_halt, o_out_valid && i_out_ready && o_alarm_level == ALARM_CRIT |=> !o_out_valid && o_in_ready, "result after halt")

endmodule

bind thermal_ema_threshold_monitor temt_checker u_temt_checker (.*);
